FILE: rtl/bsa_pkg.sv
// Package of the block slot allocator.
// Holds default sizes, operation codes and status codes; depends on nothing.
package bsa_pkg;

  localparam int unsigned SlotsPerBlockDef = 64;
  localparam int unsigned MaxBlocksDef     = 8;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic [1:0] StGranted = 2'd0;
  localparam logic [1:0] StNoSpace = 2'd1;
  localparam logic [1:0] StFreed   = 2'd2;
  localparam logic [1:0] StIgnored = 2'd3;

endpackage

FILE: rtl/bsa_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/bsa_seq.sv
// Sequencer of the block slot allocator: per-block counters, hole stack walks
// and the result register. Uses bsa_pkg and drives one hole RAM port pair.
module bsa_seq #(
  parameter int unsigned SlotsPerBlock = bsa_pkg::SlotsPerBlockDef,
  parameter int unsigned MaxBlocks     = bsa_pkg::MaxBlocksDef,
  localparam int unsigned SlotW  = $clog2(SlotsPerBlock),
  localparam int unsigned BlkW   = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1,
  localparam int unsigned AddrW  = SlotW + BlkW,
  localparam int unsigned EntW   = SlotW + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             operation_i,
  input  logic [BlkW-1:0]  block_index_i,
  input  logic [SlotW-1:0] slot_index_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [BlkW-1:0]  granted_block_o,
  output logic [SlotW-1:0] granted_slot_o,
  output logic             ram_we_o,
  output logic [AddrW-1:0] ram_waddr_o,
  output logic [EntW-1:0]  ram_wdata_o,
  output logic [AddrW-1:0] ram_raddr_o,
  input  logic [EntW-1:0]  ram_rdata_i
);

  localparam int unsigned CntW  = $clog2(SlotsPerBlock + 1);
  localparam int unsigned OpenW = $clog2(MaxBlocks + 1);
  localparam int unsigned TotW  = $clog2(SlotsPerBlock * MaxBlocks + 1);
  localparam logic [CntW-1:0]  SlotsCnt = CntW'(SlotsPerBlock);
  localparam logic [OpenW-1:0] MaxOpen  = OpenW'(MaxBlocks);
  localparam logic [AddrW-1:0] LastAddr = '1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WALK, S_TOP_CHK, S_SCAN_RD, S_SCAN_CHK, S_TRIM_RD, S_TRIM_CHK,
    S_FIND_RD, S_FIND_CHK, S_ALLOC_END, S_FREE_END, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [OpenW-1:0] open_q, open_d;
  logic [TotW-1:0]  total_q, total_d;
  logic [CntW-1:0]  bfree_q [MaxBlocks];
  logic [CntW-1:0]  bfree_d [MaxBlocks];
  logic [CntW-1:0]  top_q [MaxBlocks];
  logic [CntW-1:0]  top_d [MaxBlocks];
  logic [SlotW-1:0] lu_arr_q [MaxBlocks];
  logic [SlotW-1:0] lu_arr_d [MaxBlocks];
  logic             op_q, op_d;
  logic [BlkW-1:0]  b_q, b_d;
  logic [CntW-1:0]  i_q, i_d;
  logic [SlotW-1:0] lu_q, lu_d;
  logic             found_q, found_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [1:0]       res_st_q, res_st_d;
  logic [BlkW-1:0]  res_blk_q, res_blk_d;
  logic [SlotW-1:0] res_slot_q, res_slot_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       status_q, status_d;
  logic [BlkW-1:0]  gblk_q, gblk_d;
  logic [SlotW-1:0] gslot_q, gslot_d;

  logic             rd_valid;
  logic [SlotW-1:0] rd_slot;
  logic [CntW-1:0]  cur_top;
  logic             trim_next_free;

  assign rd_valid = ram_rdata_i[EntW-1];
  assign rd_slot  = ram_rdata_i[SlotW-1:0];
  assign cur_top  = top_q[b_q];
  assign trim_next_free = op_q;

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign granted_block_o = gblk_q;
  assign granted_slot_o  = gslot_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    open_d      = open_q;
    total_d     = total_q;
    bfree_d     = bfree_q;
    top_d       = top_q;
    lu_arr_d    = lu_arr_q;
    op_d        = op_q;
    b_d         = b_q;
    i_d         = i_q;
    lu_d        = lu_q;
    found_d     = found_q;
    slot_d      = slot_q;
    res_st_d    = res_st_q;
    res_blk_d   = res_blk_q;
    res_slot_d  = res_slot_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    gblk_d      = gblk_q;
    gslot_d     = gslot_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = {b_q, i_q[SlotW-1:0]};
    ram_wdata_o = '0;
    ram_raddr_o = {b_q, i_q[SlotW-1:0]};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        clr_d       = clr_q + 1'b1;
        if (clr_q == LastAddr) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = operation_i;
          b_d     = block_index_i;
          found_d = 1'b0;
          i_d     = '0;
          if (operation_i == bsa_pkg::OpAlloc) begin
            if (total_q == '0) begin
              res_slot_d = '0;
              if (open_q >= MaxOpen) begin
                res_st_d  = bsa_pkg::StNoSpace;
                res_blk_d = '0;
              end else begin
                // A block opens only once, so its holes are still clear.
                bfree_d[open_q[BlkW-1:0]] = SlotsCnt - 1'b1;
                open_d    = open_q + 1'b1;
                total_d   = total_q + TotW'(SlotsPerBlock - 1);
                res_st_d  = bsa_pkg::StGranted;
                res_blk_d = open_q[BlkW-1:0];
              end
              state_d = S_DONE;
            end else begin
              b_d     = BlkW'(open_q - 1'b1);
              state_d = S_WALK;
            end
          end else if (OpenW'(block_index_i) >= open_q ||
                       CntW'(slot_index_i) >= SlotsCnt) begin
            res_st_d   = bsa_pkg::StIgnored;
            res_blk_d  = '0;
            res_slot_d = '0;
            state_d    = S_DONE;
          end else if (lu_arr_q[block_index_i] == slot_index_i) begin
            if (slot_index_i == '0) begin
              top_d[block_index_i] = '0;
              state_d = S_FREE_END;
            end else begin
              lu_d = slot_index_i - 1'b1;
              lu_arr_d[block_index_i] = slot_index_i - 1'b1;
              state_d = S_FIND_RD;
            end
          end else begin
            if (top_q[block_index_i] < SlotsCnt) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = {block_index_i, top_q[block_index_i][SlotW-1:0]};
              ram_wdata_o = {1'b1, slot_index_i};
              top_d[block_index_i] = top_q[block_index_i] + 1'b1;
            end
            state_d = S_FREE_END;
          end
        end
      end
      S_WALK: begin
        if (bfree_q[b_q] != '0) begin
          if (cur_top != '0) begin
            ram_raddr_o = {b_q, SlotW'(cur_top - 1'b1)};
            state_d     = S_TOP_CHK;
          end else begin
            state_d = S_ALLOC_END;
          end
        end else if (b_q == '0) begin
          res_st_d   = bsa_pkg::StNoSpace;
          res_blk_d  = '0;
          res_slot_d = '0;
          state_d    = S_DONE;
        end else begin
          b_d = b_q - 1'b1;
        end
      end
      S_TOP_CHK: begin
        if (rd_valid) begin
          slot_d      = rd_slot;
          found_d     = 1'b1;
          ram_we_o    = 1'b1;
          ram_waddr_o = {b_q, SlotW'(cur_top - 1'b1)};
          state_d     = S_TRIM_RD;
        end else begin
          i_d     = '0;
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rd_valid) begin
          slot_d   = rd_slot;
          found_d  = 1'b1;
          ram_we_o = 1'b1;
          state_d  = S_TRIM_RD;
        end else begin
          i_d = i_q + 1'b1;
          if (i_q + 1'b1 >= cur_top) begin
            state_d = S_TRIM_RD;
          end else begin
            state_d = S_SCAN_RD;
          end
        end
      end
      S_TRIM_RD: begin
        ram_raddr_o = {b_q, SlotW'(cur_top - 1'b1)};
        if (cur_top == '0) begin
          state_d = trim_next_free ? S_FREE_END : S_ALLOC_END;
        end else begin
          state_d = S_TRIM_CHK;
        end
      end
      S_TRIM_CHK: begin
        if (!rd_valid) begin
          top_d[b_q] = cur_top - 1'b1;
          state_d    = S_TRIM_RD;
        end else begin
          state_d = trim_next_free ? S_FREE_END : S_ALLOC_END;
        end
      end
      S_FIND_RD: begin
        if (i_q >= cur_top) begin
          state_d = S_TRIM_RD;
        end else begin
          state_d = S_FIND_CHK;
        end
      end
      S_FIND_CHK: begin
        if (rd_valid && rd_slot == lu_q) begin
          ram_we_o = 1'b1;
          i_d      = '0;
          if (lu_q == '0) begin
            state_d = S_TRIM_RD;
          end else begin
            lu_d = lu_q - 1'b1;
            lu_arr_d[b_q] = lu_q - 1'b1;
            state_d = S_FIND_RD;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_FIND_RD;
        end
      end
      S_ALLOC_END: begin
        res_slot_d = slot_q;
        if (!found_q) begin
          res_slot_d    = SlotW'(SlotsCnt - bfree_q[b_q]);
          lu_arr_d[b_q] = SlotW'(SlotsCnt - bfree_q[b_q]);
        end
        bfree_d[b_q] = bfree_q[b_q] - 1'b1;
        total_d      = total_q - 1'b1;
        res_st_d     = bsa_pkg::StGranted;
        res_blk_d    = b_q;
        state_d      = S_DONE;
      end
      S_FREE_END: begin
        if (bfree_q[b_q] < SlotsCnt) begin
          bfree_d[b_q] = bfree_q[b_q] + 1'b1;
          total_d      = total_q + 1'b1;
        end
        res_st_d   = bsa_pkg::StFreed;
        res_blk_d  = '0;
        res_slot_d = '0;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_st_q;
          gblk_d      = res_blk_q;
          gslot_d     = res_slot_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      open_q      <= OpenW'(1);
      total_q     <= TotW'(SlotsPerBlock);
      out_valid_q <= 1'b0;
      for (int k = 0; k < MaxBlocks; k++) begin
        bfree_q[k]  <= SlotsCnt;
        top_q[k]    <= '0;
        lu_arr_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      open_q      <= open_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      bfree_q     <= bfree_d;
      top_q       <= top_d;
      lu_arr_q    <= lu_arr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    b_q        <= b_d;
    i_q        <= i_d;
    lu_q       <= lu_d;
    found_q    <= found_d;
    slot_q     <= slot_d;
    res_st_q   <= res_st_d;
    res_blk_q  <= res_blk_d;
    res_slot_q <= res_slot_d;
    status_q   <= status_d;
    gblk_q     <= gblk_d;
    gslot_q    <= gslot_d;
  end

  a_open_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q >= OpenW'(1) && open_q <= MaxOpen)
    else $error("open block count out of range");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside the finishing step");

  a_top_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TOP_CHK |-> cur_top != '0)
    else $error("hole stack top read on an empty stack");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |=> !out_valid_q)
    else $error("result produced during the clearing pass");

endmodule

FILE: rtl/block_slot_allocator.sv
// Top level of the block slot allocator: hole RAM plus the sequencer.
// Depends on bsa_pkg, bsa_ram and bsa_seq.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | operation_i, block_index_i, slot_index_i
//   out     | output    | out_valid_o/out_ready_i| status_o, granted_block_o, granted_slot_o
//
// After reset a clearing pass writes every hole RAM entry, one per cycle
// (MaxBlocks * SlotsPerBlock rounded up to a power of two, 512 by default);
// in_ready_o stays low meanwhile.
// An allocate walks the blocks down from the newest open one, then scans and trims hole entries;
// a free of the last used slot examines hole entries again for each step back.
// The single hole RAM read port sets the pace: each entry passes through an address and a check state.
// One item is in work at a time; a finished result waits in the output register.
module block_slot_allocator #(
  parameter int unsigned SlotsPerBlock = bsa_pkg::SlotsPerBlockDef,
  parameter int unsigned MaxBlocks     = bsa_pkg::MaxBlocksDef,
  localparam int unsigned SlotW = $clog2(SlotsPerBlock),
  localparam int unsigned BlkW  = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             operation_i,
  input  logic [BlkW-1:0]  block_index_i,
  input  logic [SlotW-1:0] slot_index_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [BlkW-1:0]  granted_block_o,
  output logic [SlotW-1:0] granted_slot_o
);

  localparam int unsigned AddrW = SlotW + BlkW;
  localparam int unsigned EntW  = SlotW + 1;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [EntW-1:0]  ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [EntW-1:0]  ram_rdata;

  bsa_ram #(
    .Width (EntW),
    .Depth (1 << AddrW)
  ) u_hole_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bsa_seq #(
    .SlotsPerBlock (SlotsPerBlock),
    .MaxBlocks     (MaxBlocks)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .block_index_i   (block_index_i),
    .slot_index_i    (slot_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .granted_block_o (granted_block_o),
    .granted_slot_o  (granted_slot_o),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata)
  );

endmodule
